[rtl/core/crc16_frame_decoder_defines.svh]
// ----------------------------------------------------------------------------
// crc16 frame decoder assertion macros
// shared concurrent assertion forms, clocked on clk and held off during rst
// ----------------------------------------------------------------------------
`ifndef CRC16_FRAME_DECODER_DEFINES_SVH
`define CRC16_FRAME_DECODER_DEFINES_SVH

// same-cycle implication
`define CRC16FD_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CRC16FD_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/crc16fd_pkg.sv]
// ----------------------------------------------------------------------------
// crc16fd_pkg
// widths, frame constants, parser phases, status codes and crc-16/arc step
// ----------------------------------------------------------------------------
package crc16fd_pkg;

  localparam int BYTE_W = 8;
  localparam int WORD_W = 16;
  localparam int CFG_W  = 17;
  localparam int POS_W  = 17;
  localparam int STAT_W = 3;
  localparam int CNT_W  = 2;

  localparam logic [BYTE_W-1:0] START_BYTE = 8'h55;
  localparam logic [BYTE_W-1:0] END_BYTE   = 8'hAA;
  localparam logic [WORD_W-1:0] CRC_POLY   = 16'hA001;

  localparam logic [CFG_W-1:0] CFG_RESET      = 17'd128;
  localparam logic [CFG_W-1:0] FRAME_OVERHEAD = 17'd9;

  // byte positions within a frame
  localparam logic [POS_W-1:0] POS_TYPE    = 17'd1;
  localparam logic [POS_W-1:0] POS_PAYLOAD = 17'd6;
  localparam logic [POS_W-1:0] POS_CRC_END = 17'd8;
  localparam logic [2:0] HDR_TYPE   = 3'd1;
  localparam logic [2:0] HDR_REG_HI = 3'd2;
  localparam logic [2:0] HDR_REG_LO = 3'd3;
  localparam logic [2:0] HDR_LEN_HI = 3'd4;

  // result queue occupancy codes
  localparam logic [CNT_W-1:0] Q_EMPTY = 2'd0;
  localparam logic [CNT_W-1:0] Q_ONE   = 2'd1;
  localparam logic [CNT_W-1:0] Q_TWO   = 2'd2;

  typedef enum logic [5:0] {
    PH_WAIT    = 6'b000001,
    PH_HEADER  = 6'b000010,
    PH_PAYLOAD = 6'b000100,
    PH_CRC     = 6'b001000,
    PH_END     = 6'b010000,
    PH_SKIP    = 6'b100000
  } phase_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_BAD_START = 3'd1,
    ST_TOO_LONG  = 3'd2,
    ST_BAD_END   = 3'd3,
    ST_CRC       = 3'd4,
    ST_EARLY     = 3'd5
  } status_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_STATUS  = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [BYTE_W-1:0]   payload_byte;
    logic [WORD_W-1:0]   payload_index;
    logic [BYTE_W-1:0]   msg_type;
    logic [WORD_W-1:0]   reg_number;
    logic [WORD_W-1:0]   content_length;
    status_t             status;
    logic                last;
  } result_t;

  // one byte through reflected crc-16/arc, lsb first
  function automatic logic [WORD_W-1:0] crc16_arc_byte(input logic [WORD_W-1:0] crc,
                                                       input logic [BYTE_W-1:0] data);
    logic [WORD_W-1:0] c;
    c = crc ^ {{(WORD_W-BYTE_W){1'b0}}, data};
    for (int i = 0; i < BYTE_W; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[rtl/core/crc16fd_channels.sv]
// ----------------------------------------------------------------------------
// crc16fd channels
// valid/ready channels for received bytes and for decoder results
// ----------------------------------------------------------------------------
interface crc16fd_rx_if;
  logic                             valid;
  logic                             ready;
  logic [crc16fd_pkg::BYTE_W-1:0]   rx_byte;
  logic                             transaction_end;

  modport source (output valid, output rx_byte, output transaction_end, input ready);
  modport sink   (input valid, input rx_byte, input transaction_end, output ready);
endinterface

interface crc16fd_res_if;
  logic                             valid;
  logic                             ready;
  logic                             result_kind;
  logic [crc16fd_pkg::BYTE_W-1:0]   payload_byte;
  logic [crc16fd_pkg::WORD_W-1:0]   payload_index;
  logic [crc16fd_pkg::BYTE_W-1:0]   msg_type;
  logic [crc16fd_pkg::WORD_W-1:0]   reg_number;
  logic [crc16fd_pkg::WORD_W-1:0]   content_length;
  logic [crc16fd_pkg::STAT_W-1:0]   status;
  logic                             last;

  modport source (output valid, output result_kind, output payload_byte,
                  output payload_index, output msg_type, output reg_number,
                  output content_length, output status, output last, input ready);
  modport sink   (input valid, input result_kind, input payload_byte,
                  input payload_index, input msg_type, input reg_number,
                  input content_length, input status, input last, output ready);
endinterface

[rtl/core/crc16_frame_decoder.sv]
// ----------------------------------------------------------------------------
// crc16_frame_decoder: streaming parser for crc-16/arc framed register messages
// results of each taken byte are registered into a three-entry result queue
// throughput: one byte per cycle while at most one result waits; a payload byte
//   ending a transaction makes two results, drained one per res.ready cycle
// reset: synchronous rst returns to wait for start, limit 128, queue empty
// ----------------------------------------------------------------------------
`include "crc16_frame_decoder_defines.svh"

module crc16_frame_decoder (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [crc16fd_pkg::CFG_W-1:0]  cfg_wr_data,
  crc16fd_rx_if.sink                     rx,
  crc16fd_res_if.source                  res
);

  // parser state
  logic [crc16fd_pkg::CFG_W-1:0]  frame_buffer_bytes;
  crc16fd_pkg::phase_t            phase, phase_next;
  logic [crc16fd_pkg::POS_W-1:0]  byte_position, byte_position_next;
  logic [crc16fd_pkg::WORD_W-1:0] running_crc, running_crc_next;
  logic [crc16fd_pkg::BYTE_W-1:0] frame_type, frame_type_next;
  logic [crc16fd_pkg::WORD_W-1:0] register_field, register_field_next;
  logic [crc16fd_pkg::WORD_W-1:0] length_field, length_field_next;
  logic [crc16fd_pkg::WORD_W-1:0] received_crc, received_crc_next;

  // result queue
  crc16fd_pkg::result_t           q [0:2];
  crc16fd_pkg::result_t           q_next [0:2];
  logic [crc16fd_pkg::CNT_W-1:0]  count, count_next;

  logic                           accept;
  logic                           pop;
  logic                           emit_pay;
  logic                           emit_stat;
  logic                           emit_early;
  crc16fd_pkg::status_t           stat_code;
  logic [crc16fd_pkg::POS_W-1:0]  pos_inc;
  logic [crc16fd_pkg::POS_W-1:0]  pay_off;
  logic [crc16fd_pkg::BYTE_W-1:0] b;
  crc16fd_pkg::result_t           r_pay, r_stat, new0, new1;
  logic [crc16fd_pkg::CNT_W-1:0]  push_n;
  logic [crc16fd_pkg::CNT_W-1:0]  base;
  crc16fd_pkg::result_t           sh0, sh1;

  assign b       = rx.rx_byte;
  assign accept  = rx.valid & rx.ready;
  assign pop     = (count != crc16fd_pkg::Q_EMPTY) & res.ready;
  assign pos_inc = byte_position + 17'd1;
  assign pay_off = byte_position - crc16fd_pkg::POS_PAYLOAD;

  // frame parser, one byte per step
  always_comb begin
    phase_next          = phase;
    byte_position_next  = byte_position;
    running_crc_next    = running_crc;
    frame_type_next     = frame_type;
    register_field_next = register_field;
    length_field_next   = length_field;
    received_crc_next   = received_crc;
    emit_pay            = 1'b0;
    emit_stat           = 1'b0;
    emit_early          = 1'b0;
    stat_code           = crc16fd_pkg::ST_OK;
    case (phase)
      crc16fd_pkg::PH_WAIT: begin
        running_crc_next    = '0;
        frame_type_next     = '0;
        register_field_next = '0;
        length_field_next   = '0;
        received_crc_next   = '0;
        if (b == crc16fd_pkg::START_BYTE) begin
          phase_next         = crc16fd_pkg::PH_HEADER;
          byte_position_next = crc16fd_pkg::POS_TYPE;
        end else begin
          emit_stat  = 1'b1;
          stat_code  = crc16fd_pkg::ST_BAD_START;
          phase_next = crc16fd_pkg::PH_SKIP;
        end
      end
      crc16fd_pkg::PH_HEADER: begin
        running_crc_next = crc16fd_pkg::crc16_arc_byte(running_crc, b);
        case (byte_position[2:0])
          crc16fd_pkg::HDR_TYPE:   frame_type_next = b;
          crc16fd_pkg::HDR_REG_HI: register_field_next = {b, register_field[7:0]};
          crc16fd_pkg::HDR_REG_LO: register_field_next = {register_field[15:8], b};
          crc16fd_pkg::HDR_LEN_HI: length_field_next = {b, length_field[7:0]};
          default:                 length_field_next = {length_field[15:8], b};
        endcase
        byte_position_next = pos_inc;
        // length check right after the low length byte
        if (pos_inc >= crc16fd_pkg::POS_PAYLOAD) begin
          byte_position_next = crc16fd_pkg::POS_PAYLOAD;
          if (frame_buffer_bytes <
              crc16fd_pkg::FRAME_OVERHEAD + {1'b0, length_field_next}) begin
            emit_stat  = 1'b1;
            stat_code  = crc16fd_pkg::ST_TOO_LONG;
            phase_next = crc16fd_pkg::PH_SKIP;
          end else if (length_field_next != '0) begin
            phase_next = crc16fd_pkg::PH_PAYLOAD;
          end else begin
            phase_next = crc16fd_pkg::PH_CRC;
          end
        end
      end
      crc16fd_pkg::PH_PAYLOAD: begin
        running_crc_next   = crc16fd_pkg::crc16_arc_byte(running_crc, b);
        emit_pay           = 1'b1;
        byte_position_next = pos_inc;
        if (pos_inc - crc16fd_pkg::POS_PAYLOAD >= {1'b0, length_field}) begin
          phase_next = crc16fd_pkg::PH_CRC;
        end
      end
      crc16fd_pkg::PH_CRC: begin
        received_crc_next  = {received_crc[7:0], b};
        byte_position_next = pos_inc;
        if (pos_inc >= crc16fd_pkg::POS_CRC_END + {1'b0, length_field}) begin
          phase_next = crc16fd_pkg::PH_END;
        end
      end
      crc16fd_pkg::PH_END: begin
        emit_stat  = 1'b1;
        phase_next = crc16fd_pkg::PH_SKIP;
        if (b != crc16fd_pkg::END_BYTE) begin
          stat_code = crc16fd_pkg::ST_BAD_END;
        end else if (received_crc != running_crc) begin
          stat_code = crc16fd_pkg::ST_CRC;
        end else begin
          stat_code = crc16fd_pkg::ST_OK;
        end
      end
      default: begin
      end
    endcase
    // end of transaction
    if (rx.transaction_end) begin
      if (phase_next != crc16fd_pkg::PH_SKIP) begin
        emit_early = 1'b1;
      end
      phase_next         = crc16fd_pkg::PH_WAIT;
      byte_position_next = '0;
    end
  end

  // result words for this byte
  always_comb begin
    r_pay.kind           = crc16fd_pkg::KIND_PAYLOAD;
    r_pay.payload_byte   = b;
    r_pay.payload_index  = pay_off[crc16fd_pkg::WORD_W-1:0];
    r_pay.msg_type       = frame_type_next;
    r_pay.reg_number     = register_field_next;
    r_pay.content_length = length_field_next;
    r_pay.status         = crc16fd_pkg::ST_OK;
    r_pay.last           = ~emit_early;

    r_stat.kind           = crc16fd_pkg::KIND_STATUS;
    r_stat.payload_byte   = '0;
    r_stat.payload_index  = '0;
    r_stat.msg_type       = frame_type_next;
    r_stat.reg_number     = register_field_next;
    r_stat.content_length = length_field_next;
    r_stat.status         = emit_stat ? stat_code : crc16fd_pkg::ST_EARLY;
    r_stat.last           = 1'b1;

    new0   = emit_pay ? r_pay : r_stat;
    new1   = r_stat;
    push_n = accept ? ({1'b0, emit_pay} + {1'b0, emit_stat | emit_early}) : '0;
  end

  // queue shift on pop, append new words behind what is left
  always_comb begin
    base = count - {1'b0, pop};
    sh0  = pop ? q[1] : q[0];
    sh1  = pop ? q[2] : q[1];

    q_next[0] = (base == crc16fd_pkg::Q_EMPTY) ? new0 : sh0;

    if (base == crc16fd_pkg::Q_EMPTY) begin
      q_next[1] = new1;
    end else if (base == crc16fd_pkg::Q_ONE) begin
      q_next[1] = new0;
    end else begin
      q_next[1] = sh1;
    end

    if (base == crc16fd_pkg::Q_ONE) begin
      q_next[2] = new1;
    end else if (base == crc16fd_pkg::Q_TWO) begin
      q_next[2] = new0;
    end else begin
      q_next[2] = q[2];
    end

    count_next = base + push_n;
  end

  // control and parser registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_buffer_bytes <= crc16fd_pkg::CFG_RESET;
      phase              <= crc16fd_pkg::PH_WAIT;
      byte_position      <= '0;
      running_crc        <= '0;
      frame_type         <= '0;
      register_field     <= '0;
      length_field       <= '0;
      received_crc       <= '0;
      count              <= crc16fd_pkg::Q_EMPTY;
    end else begin
      if (cfg_wr_en) begin
        frame_buffer_bytes <= cfg_wr_data;
      end
      if (accept) begin
        phase          <= phase_next;
        byte_position  <= byte_position_next;
        running_crc    <= running_crc_next;
        frame_type     <= frame_type_next;
        register_field <= register_field_next;
        length_field   <= length_field_next;
        received_crc   <= received_crc_next;
      end
      count <= count_next;
    end
  end

  // queue payload
  always_ff @(posedge clk) begin
    q[0] <= q_next[0];
    q[1] <= q_next[1];
    q[2] <= q_next[2];
  end

  // channel outputs
  assign rx.ready           = (count <= crc16fd_pkg::Q_ONE);
  assign res.valid          = (count != crc16fd_pkg::Q_EMPTY);
  assign res.result_kind    = q[0].kind;
  assign res.payload_byte   = q[0].payload_byte;
  assign res.payload_index  = q[0].payload_index;
  assign res.msg_type       = q[0].msg_type;
  assign res.reg_number     = q[0].reg_number;
  assign res.content_length = q[0].content_length;
  assign res.status         = q[0].status;
  assign res.last           = q[0].last;

  // checks
  `CRC16FD_ASSERT_IMPL(a_status_is_last,
    res.valid && (q[0].kind == crc16fd_pkg::KIND_STATUS), q[0].last,
    "status word not marked last")
  `CRC16FD_ASSERT_IMPL(a_payload_ok,
    res.valid && (q[0].kind == crc16fd_pkg::KIND_PAYLOAD),
    q[0].status == crc16fd_pkg::ST_OK, "payload word carries a status code")
  `CRC16FD_ASSERT_NEXT(a_end_to_wait, accept && rx.transaction_end,
    phase == crc16fd_pkg::PH_WAIT, "parser not back at start after transaction end")
  `CRC16FD_ASSERT_IMPL(a_bad_start_clear,
    res.valid && (q[0].status == crc16fd_pkg::ST_BAD_START),
    (q[0].msg_type == '0) && (q[0].reg_number == '0) && (q[0].content_length == '0),
    "bad start word carries stale header fields")

endmodule
